// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/rtt_pkg.sv =====
// Types, codes and constants of the RTT estimator
`timescale 1ns / 1ps

package rtt_pkg;

  localparam int unsigned OUT_W        = 32;
  localparam int unsigned NOW_W        = 63;
  localparam int unsigned MODE_W       = 2;
  localparam int unsigned TIME_WIDTH_D = 32;

  localparam logic [MODE_W-1:0] MODE_SAMPLE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_EXPIRE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MIGRATE = 2'd2;

  localparam logic [OUT_W-1:0] ONE_SECOND_US  = 32'd1000000;
  localparam logic [OUT_W-1:0] INIT_RTT_RESET = 32'd100000;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [OUT_W-1:0]  send_delta_us;
    logic [OUT_W-1:0]  ack_delay_us;
    logic [NOW_W-1:0]  now_us;
  } rtt_in_t;

  typedef struct packed {
    logic [OUT_W-1:0] smoothed_rtt_us;
    logic [OUT_W-1:0] mean_deviation_us;
    logic [OUT_W-1:0] min_rtt_us;
    logic [OUT_W-1:0] latest_rtt_us;
    logic [OUT_W-1:0] previous_srtt_us;
    logic [NOW_W-1:0] last_update_us;
    logic             took_min_path;
  } rtt_out_t;

endpackage

// ===== rtl/core/rtt_ifs.sv =====
// Valid/ready stream interfaces for the RTT estimator channels
`timescale 1ns / 1ps

interface rtt_in_if;
  logic             valid;
  logic             ready;
  rtt_pkg::rtt_in_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface rtt_out_if;
  logic              valid;
  logic              ready;
  rtt_pkg::rtt_out_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/core/rtt_estimator.sv =====
// RTT estimator top level: input register, state update and result register
//
// Usage:
//   in_ch carries one command per transaction: mode 0 takes an RTT sample
//   (send delta, ACK delay, timestamp), mode 1 expires the smoothed metrics,
//   mode 2 resets the estimate for connection migration; mode 3 changes nothing.
//   out_ch returns one transaction per command: the estimator state after it.
//   cfg_we/cfg_wdata write the initial smoothed RTT, used at the next
//   migration. Write it only while no command is in flight.
//   A command passes the input register and then the result register.
//   Throughput: one command per cycle while out_ch.ready stays high; the
//   update of the single state set from the registered command bounds the rate.
//   Reset (rst_n low, synchronous): pipeline empty, state back to its initial
//   values, initial RTT register back to 100000 us.
//   Receiver stall: the result register holds, the input register fills and
//   in_ch.ready drops until out_ch.ready returns.
//   RTT values are held in min(TIME_WIDTH, 32) bits.
`timescale 1ns / 1ps

module rtt_estimator #(
  parameter int unsigned TIME_WIDTH = rtt_pkg::TIME_WIDTH_D
) (
  input  logic                      clk,
  input  logic                      rst_n,
  rtt_in_if.sink                    in_ch,
  rtt_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [rtt_pkg::OUT_W-1:0] cfg_wdata
);

  localparam int unsigned RW = (TIME_WIDTH < rtt_pkg::OUT_W) ? TIME_WIDTH : rtt_pkg::OUT_W;

  logic                     s1_valid_r;
  rtt_pkg::rtt_in_t         s1_data_r;
  logic                     out_valid_r;
  rtt_pkg::rtt_out_t        out_data_r;
  logic                     s1_adv;
  logic                     s1_fire;
  logic                     in_fire;

  logic [RW-1:0]            init_rtt_r;
  logic [RW-1:0]            latest_r;
  logic [RW-1:0]            min_r;
  logic [RW-1:0]            srtt_r;
  logic [RW-1:0]            prior_r;
  logic [RW-1:0]            dev_r;
  logic [rtt_pkg::NOW_W-1:0] last_r;

  logic [RW-1:0]            latest_nxt;
  logic [RW-1:0]            min_nxt;
  logic [RW-1:0]            srtt_nxt;
  logic [RW-1:0]            prior_nxt;
  logic [RW-1:0]            dev_nxt;
  logic [rtt_pkg::NOW_W-1:0] last_nxt;
  logic                     took_min;

  assign s1_adv       = !out_valid_r || out_ch.ready;
  assign s1_fire      = s1_valid_r && s1_adv;
  assign in_ch.ready  = !s1_valid_r || s1_adv;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  rtt_update #(
    .RW(RW)
  ) u_update (
    .mode      (s1_data_r.mode),
    .delta     (s1_data_r.send_delta_us[RW-1:0]),
    .ackd      (s1_data_r.ack_delay_us[RW-1:0]),
    .now       (s1_data_r.now_us),
    .init_rtt  (init_rtt_r),
    .latest    (latest_r),
    .min_rtt   (min_r),
    .srtt      (srtt_r),
    .prior     (prior_r),
    .dev       (dev_r),
    .last      (last_r),
    .latest_nxt(latest_nxt),
    .min_nxt   (min_nxt),
    .srtt_nxt  (srtt_nxt),
    .prior_nxt (prior_nxt),
    .dev_nxt   (dev_nxt),
    .last_nxt  (last_nxt),
    .took_min  (took_min)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= in_fire || (s1_valid_r && !s1_adv);
      out_valid_r <= s1_fire || (out_valid_r && !out_ch.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_rtt_r <= rtt_pkg::INIT_RTT_RESET[RW-1:0];
    end else if (cfg_we) begin
      init_rtt_r <= cfg_wdata[RW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latest_r <= '0;
      min_r    <= rtt_pkg::ONE_SECOND_US[RW-1:0];
      srtt_r   <= rtt_pkg::INIT_RTT_RESET[RW-1:0];
      prior_r  <= '0;
      dev_r    <= '0;
      last_r   <= '0;
    end else if (s1_fire) begin
      latest_r <= latest_nxt;
      min_r    <= min_nxt;
      srtt_r   <= srtt_nxt;
      prior_r  <= prior_nxt;
      dev_r    <= dev_nxt;
      last_r   <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r <= in_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data_r.smoothed_rtt_us   <= rtt_pkg::OUT_W'(srtt_nxt);
      out_data_r.mean_deviation_us <= rtt_pkg::OUT_W'(dev_nxt);
      out_data_r.min_rtt_us        <= rtt_pkg::OUT_W'(min_nxt);
      out_data_r.latest_rtt_us     <= rtt_pkg::OUT_W'(latest_nxt);
      out_data_r.previous_srtt_us  <= rtt_pkg::OUT_W'(prior_nxt);
      out_data_r.last_update_us    <= last_nxt;
      out_data_r.took_min_path     <= took_min;
    end
  end

endmodule

// ===== rtl/core/rtt_update.sv =====
// Combinational next-state logic of the RTT estimator
`timescale 1ns / 1ps

module rtt_update #(
  parameter int unsigned RW = rtt_pkg::TIME_WIDTH_D
) (
  input  logic [rtt_pkg::MODE_W-1:0] mode,
  input  logic [RW-1:0]              delta,
  input  logic [RW-1:0]              ackd,
  input  logic [rtt_pkg::NOW_W-1:0]  now,
  input  logic [RW-1:0]              init_rtt,
  input  logic [RW-1:0]              latest,
  input  logic [RW-1:0]              min_rtt,
  input  logic [RW-1:0]              srtt,
  input  logic [RW-1:0]              prior,
  input  logic [RW-1:0]              dev,
  input  logic [rtt_pkg::NOW_W-1:0]  last,
  output logic [RW-1:0]              latest_nxt,
  output logic [RW-1:0]              min_nxt,
  output logic [RW-1:0]              srtt_nxt,
  output logic [RW-1:0]              prior_nxt,
  output logic [RW-1:0]              dev_nxt,
  output logic [rtt_pkg::NOW_W-1:0]  last_nxt,
  output logic                       took_min
);

  logic          min_path;
  logic          sub_ack;
  logic [RW-1:0] sample;
  logic [RW-1:0] blend_x;
  logic [RW+2:0] blend_sum;
  logic [RW-1:0] blend;
  logic [RW-1:0] smp_diff;
  logic [RW+1:0] dev_sum;
  logic [RW-1:0] dev_smp;
  logic [RW-1:0] exp_diff;
  logic [RW-1:0] delta_m_min;

  assign min_path    = (min_rtt > delta) && (delta > (srtt >> 1));
  assign delta_m_min = delta - min_rtt;
  assign sub_ack     = (delta >= min_rtt) && (delta_m_min >= ackd);
  assign sample      = sub_ack ? (delta - ackd) : delta;
  assign blend_x     = min_path ? delta : sample;

  assign blend_sum = ({3'b000, srtt} << 2) + ({3'b000, srtt} << 1) + ({3'b000, blend_x} << 1);
  assign blend     = blend_sum[RW+2:3];

  assign smp_diff = (srtt > sample) ? (srtt - sample) : (sample - srtt);
  assign dev_sum  = ({2'b00, dev} << 1) + {2'b00, dev} + {2'b00, smp_diff};
  assign dev_smp  = dev_sum[RW+1:2];

  assign exp_diff = (srtt > latest) ? (srtt - latest) : (latest - srtt);

  always_comb begin
    latest_nxt = latest;
    min_nxt    = min_rtt;
    srtt_nxt   = srtt;
    prior_nxt  = prior;
    dev_nxt    = dev;
    last_nxt   = last;
    took_min   = 1'b0;
    case (mode)
      rtt_pkg::MODE_SAMPLE: begin
        last_nxt  = now;
        prior_nxt = srtt;
        srtt_nxt  = blend;
        if (min_path) begin
          min_nxt    = delta;
          latest_nxt = delta;
          took_min   = 1'b1;
        end else begin
          latest_nxt = sample;
          dev_nxt    = dev_smp;
        end
      end
      rtt_pkg::MODE_EXPIRE: begin
        if (exp_diff > dev) begin
          dev_nxt = exp_diff;
        end
        if (latest > srtt) begin
          srtt_nxt = latest;
        end
      end
      rtt_pkg::MODE_MIGRATE: begin
        latest_nxt = '0;
        min_nxt    = rtt_pkg::ONE_SECOND_US[RW-1:0];
        srtt_nxt   = init_rtt;
        dev_nxt    = '0;
      end
      default: begin
        took_min = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/core/rtt_estimator_chk.sv =====
// Port-level checker for the RTT estimator, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rtt_estimator_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input rtt_pkg::rtt_out_t out_data
);

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result transaction changed or dropped")

  `ASSERT_IMPLIES(a_in_ready, clk, rst_n, !out_valid || out_ready, in_ready, "input stalled while the result side can advance")

  `ASSERT_IMPLIES(a_min_match, clk, rst_n, out_valid && out_data.took_min_path, out_data.min_rtt_us == out_data.latest_rtt_us, "new-minimum result with min and latest RTT apart")

  `ASSERT_IMPLIES(a_min_nonzero, clk, rst_n, out_valid && out_data.took_min_path, out_data.latest_rtt_us != 32'd0, "new-minimum result with a zero sample")

endmodule

bind rtt_estimator rtt_estimator_chk u_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_ready (in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_data (out_ch.data)
);
